/* src/gdoy_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdoy_pkg
// Shared widths, constants, status codes and month tables for the Gregorian
// date to aligned year and day-in-year converter.
// ----------------------------------------------------------------------------
package gdoy_pkg;

    localparam int YEAR_BITS  = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 6;
    localparam int DOY_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // year + 4800 and year + 4900 stay below 2**YEAR_BITS for accepted years
    localparam int K_W     = YEAR_BITS;
    localparam int A_W     = 25;          // 1461 * (k + 4800)
    localparam int Q100_W  = 8;           // (k + 4900) / 100
    localparam int JD_W    = 23;          // julian day number minus one
    localparam int CYC_W   = 12;          // four-year cycle count
    localparam int RCP_W   = 22;
    localparam int L_W     = 11;          // day within the four-year cycle
    localparam int R_W     = 12;          // uncorrected remainder, below 2 * 1461

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_YEAR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MONTH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DAY   = 2'd3;

    localparam int MIN_YEAR     = -4711;
    localparam int CYCLE_DAYS   = 1461;
    localparam int JD_OFFSET    = 30661;  // 30660 plus the one taken off jd
    localparam int YEAR_OFFSET  = 4716;

    // floor(x / 100) = (x * 5243) >> 19 for x below 43690
    localparam int RECIP_100    = 5243;
    localparam int RECIP_100_SH = 19;

    // floor(2**32 / 1461), estimate is the quotient or one below it
    localparam logic [RCP_W-1:0] RECIP_1461 = 22'd2939744;
    localparam int RECIP_1461_SH = 32;

    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
    } split_en_t;

    // (367 * (m - 2 + 12 * adj)) / 12 for each month
    function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // month length in a common year
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] v;
        unique case (m) inside
            4'd2:                     v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  v = 5'd30;
            default:                  v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

/* src/gdoy_cycle_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdoy_cycle_split
// Three-stage split of a julian day number into four-year cycles: reciprocal
// multiply, remainder, then correction and year-in-cycle.
// ----------------------------------------------------------------------------
module gdoy_cycle_split (
    input  logic                     aclk,
    input  gdoy_pkg::split_en_t      en,
    input  logic [gdoy_pkg::JD_W-1:0] jd_m1,
    output logic [gdoy_pkg::CYC_W-1:0] cyc,
    output logic [gdoy_pkg::L_W-1:0]   lday,
    output logic [1:0]                 nyear
);
    import gdoy_pkg::*;

    localparam int PROD_W = JD_W + RCP_W;

    logic [CYC_W-1:0]  s4_q_reg;
    logic [JD_W-1:0]   s4_jd_reg;
    logic [R_W-1:0]    s5_r_reg;
    logic [CYC_W-1:0]  s5_q_reg;
    logic [CYC_W-1:0]  s6_cyc_reg;
    logic [L_W-1:0]    s6_l_reg;
    logic [1:0]        s6_n_reg;

    logic [JD_W-1:0]   r_full;
    logic [R_W-1:0]    r_fix;
    logic [CYC_W-1:0]  q_fix;
    logic [1:0]        n_next;

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            s4_q_reg  <= CYC_W'((PROD_W'(jd_m1) * PROD_W'(RECIP_1461)) >> RECIP_1461_SH);
            s4_jd_reg <= jd_m1;
        end
    end

    assign r_full = s4_jd_reg - JD_W'(JD_W'(s4_q_reg) * JD_W'(CYCLE_DAYS));

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            s5_r_reg <= r_full[R_W-1:0];
            s5_q_reg <= s4_q_reg;
        end
    end

    always_comb begin
        if (s5_r_reg >= R_W'(CYCLE_DAYS)) begin
            r_fix = s5_r_reg - R_W'(CYCLE_DAYS);
            q_fix = s5_q_reg + CYC_W'(1);
        end else begin
            r_fix = s5_r_reg;
            q_fix = s5_q_reg;
        end
        // last day of a cycle (r = 1460) belongs to the fourth year
        if (r_fix >= R_W'(1095))
            n_next = 2'd3;
        else if (r_fix >= R_W'(730))
            n_next = 2'd2;
        else if (r_fix >= R_W'(365))
            n_next = 2'd1;
        else
            n_next = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (en.s6) begin
            s6_cyc_reg <= q_fix;
            s6_l_reg   <= L_W'(r_fix) + L_W'(1);
            s6_n_reg   <= n_next;
        end
    end

    assign cyc   = s6_cyc_reg;
    assign lday  = s6_l_reg;
    assign nyear = s6_n_reg;

endmodule

/* src/gregorian_date_to_day_of_year_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_to_day_of_year_core
// Gregorian date to year and day-in-year of a century-aligned julian calendar.
// ----------------------------------------------------------------------------
// pipeline: seven register stages from input accept to output (date terms,
//   constant multiplies, jd sum, 1461 split x3, output)
// throughput: one item per cycle; each stage stalls only when the one after
//   it is full and held
// reset: clears every stage valid bit and sets century default enable to 1
// ----------------------------------------------------------------------------
module gregorian_date_to_day_of_year_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // greg_year [13:0], greg_month [17:14], greg_day [23:18]
    input  logic [gdoy_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // aligned_year [13:0], day_in_year [22:14], status [24:23], zero [31:25]
    output logic [gdoy_pkg::OUT_DATA_W-1:0] m_tdata
);
    import gdoy_pkg::*;

    localparam int KW = YEAR_BITS + 2;
    localparam logic signed [YEAR_BITS-1:0] Y_MIN = YEAR_BITS'(MIN_YEAR);
    localparam logic signed [YEAR_BITS-1:0] Y_2000 = YEAR_BITS'(2000);
    localparam logic signed [YEAR_BITS-1:0] Y_1900 = YEAR_BITS'(1900);
    localparam logic signed [YEAR_BITS-1:0] Y_49 = YEAR_BITS'(49);
    localparam logic signed [YEAR_BITS-1:0] Y_99 = YEAR_BITS'(99);
    localparam int PC_W = K_W + 13;

    logic cen_def_reg;

    logic [7:1] vld_reg;
    logic [7:1] vld_in;
    logic [7:1] en;

    // stage 1 inputs
    logic signed [YEAR_BITS-1:0] y_in;
    logic signed [YEAR_BITS-1:0] y_def;
    logic [MONTH_W-1:0]          m_in;
    logic [DAY_W-1:0]            d_in;
    logic                        adj;
    logic signed [KW-1:0]        k_wide;
    logic signed [KW-1:0]        u_wide;
    logic [STATUS_W-1:0]         st_in;

    logic [K_W-1:0]      s1_kp_reg;
    logic [K_W-1:0]      s1_kc_reg;
    logic [K_W-1:0]      s1_u_reg;
    logic [8:0]          s1_b_reg;
    logic [DAY_W-1:0]    s1_d_reg;
    logic [4:0]          s1_mlen_reg;
    logic                s1_feb_reg;
    logic [STATUS_W-1:0] s1_st_reg;

    logic [A_W-1:0]      s2_a_reg;
    logic [Q100_W-1:0]   s2_qc_reg;
    logic [Q100_W-1:0]   s2_qu_reg;
    logic [K_W-1:0]      s2_u_reg;
    logic [8:0]          s2_b_reg;
    logic [DAY_W-1:0]    s2_d_reg;
    logic [4:0]          s2_mlen_reg;
    logic                s2_feb_reg;
    logic [STATUS_W-1:0] s2_st_reg;

    logic [JD_W-1:0]     jd_next;
    logic [9:0]          c3;
    logic [K_W-1:0]      rem100;
    logic                leap;
    logic [4:0]          mlen;
    logic [STATUS_W-1:0] st3;

    logic [JD_W-1:0]     s3_jd_reg;
    logic [STATUS_W-1:0] s3_st_reg;
    logic [STATUS_W-1:0] s4_st_reg;
    logic [STATUS_W-1:0] s5_st_reg;
    logic [STATUS_W-1:0] s6_st_reg;

    split_en_t           split_en;
    logic [CYC_W-1:0]    cyc;
    logic [L_W-1:0]      lday;
    logic [1:0]          nyear;

    logic [8:0]          t_day;
    logic                mm;
    logic [2:0]          yi;
    logic [DOY_W-1:0]    nd;
    logic [YEAR_BITS-1:0] ny;

    logic [YEAR_BITS-1:0] s7_year_reg;
    logic [DOY_W-1:0]     s7_doy_reg;
    logic [STATUS_W-1:0]  s7_st_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_def_reg <= 1'b1;
        end else if (cfg_we) begin
            cen_def_reg <= cfg_wdata;
        end
    end

    // stage handshake: a stage takes new data when empty or when it moves on
    always_comb begin
        en[7] = !vld_reg[7] || m_tready;
        for (int i = 6; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in = {vld_reg[6:1], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= 7; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[7];

    // stage 1: century default, range checks, month terms
    assign y_in = signed'(s_tdata[YEAR_BITS-1:0]);
    assign m_in = s_tdata[YEAR_BITS +: MONTH_W];
    assign d_in = s_tdata[YEAR_BITS+MONTH_W +: DAY_W];

    always_comb begin
        y_def = y_in;
        if (cen_def_reg && y_in >= 0 && y_in <= Y_99) begin
            y_def = (y_in <= Y_49) ? y_in + Y_2000 : y_in + Y_1900;
        end
        adj    = (m_in <= MONTH_W'(2));
        u_wide = KW'(y_def) + KW'(4800);
        k_wide = u_wide - KW'(adj);
        if (y_def < Y_MIN)
            st_in = STATUS_BAD_YEAR;
        else if (m_in == MONTH_W'(0) || m_in > MONTH_W'(12))
            st_in = STATUS_BAD_MONTH;
        else
            st_in = STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_kp_reg   <= k_wide[K_W-1:0];
            s1_kc_reg   <= k_wide[K_W-1:0] + K_W'(100);
            s1_u_reg    <= u_wide[K_W-1:0];
            s1_b_reg    <= month_term(m_in);
            s1_d_reg    <= d_in;
            s1_mlen_reg <= month_len(m_in);
            s1_feb_reg  <= (m_in == MONTH_W'(2));
            s1_st_reg   <= st_in;
        end
    end

    // stage 2: constant multiplies
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_a_reg    <= A_W'(s1_kp_reg) * A_W'(CYCLE_DAYS);
            s2_qc_reg   <= Q100_W'((PC_W'(s1_kc_reg) * PC_W'(RECIP_100)) >> RECIP_100_SH);
            s2_qu_reg   <= Q100_W'((PC_W'(s1_u_reg) * PC_W'(RECIP_100)) >> RECIP_100_SH);
            s2_u_reg    <= s1_u_reg;
            s2_b_reg    <= s1_b_reg;
            s2_d_reg    <= s1_d_reg;
            s2_mlen_reg <= s1_mlen_reg;
            s2_feb_reg  <= s1_feb_reg;
            s2_st_reg   <= s1_st_reg;
        end
    end

    // stage 3: julian day number, leap rule and day check
    always_comb begin
        c3      = (10'(s2_qc_reg) * 10'd3) >> 2;
        jd_next = JD_W'(s2_a_reg >> 2) + JD_W'(s2_b_reg) + JD_W'(s2_d_reg)
                - JD_W'(c3) - JD_W'(JD_OFFSET);
        // year + 4800 keeps divisibility by 4, 100 and 400
        rem100  = s2_u_reg - K_W'(K_W'(s2_qu_reg) * K_W'(100));
        leap    = (s2_u_reg[1:0] == 2'b00)
               && ((rem100 != '0) || (s2_qu_reg[1:0] == 2'b00));
        mlen    = s2_mlen_reg + 5'(s2_feb_reg && leap);
        if (s2_st_reg != STATUS_OK)
            st3 = s2_st_reg;
        else if (s2_d_reg == '0 || s2_d_reg > DAY_W'(mlen))
            st3 = STATUS_BAD_DAY;
        else
            st3 = STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_jd_reg <= jd_next;
            s3_st_reg <= st3;
        end
    end

    // stages 4 to 6: four-year cycle split
    assign split_en.s4 = en[4];
    assign split_en.s5 = en[5];
    assign split_en.s6 = en[6];

    gdoy_cycle_split u_split (
        .aclk  (aclk),
        .en    (split_en),
        .jd_m1 (s3_jd_reg),
        .cyc   (cyc),
        .lday  (lday),
        .nyear (nyear)
    );

    always_ff @(posedge aclk) begin
        if (en[4]) s4_st_reg <= s3_st_reg;
        if (en[5]) s5_st_reg <= s4_st_reg;
        if (en[6]) s6_st_reg <= s5_st_reg;
    end

    // stage 7: year in cycle, day in year, output register
    always_comb begin
        t_day = 9'(lday - L_W'(L_W'(nyear) * L_W'(365)));
        // days from january onward spill into the next julian year
        mm    = (t_day >= 9'd307);
        yi    = 3'(nyear) + 3'(mm);
        if (mm)
            nd = t_day - 9'd306;
        else
            nd = t_day + 9'd59 + 9'(nyear == 2'd0);
        ny    = YEAR_BITS'({cyc, 2'b00}) + YEAR_BITS'(yi) - YEAR_BITS'(YEAR_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            s7_st_reg <= s6_st_reg;
            if (s6_st_reg == STATUS_BAD_YEAR || s6_st_reg == STATUS_BAD_MONTH) begin
                s7_year_reg <= '0;
                s7_doy_reg  <= '0;
            end else begin
                s7_year_reg <= ny;
                s7_doy_reg  <= nd;
            end
        end
    end

    assign m_tdata = {{(OUT_DATA_W-YEAR_BITS-DOY_W-STATUS_W){1'b0}},
                      s7_st_reg, s7_doy_reg, s7_year_reg};

endmodule
